FILE: rtl/core/dqve_pkg.sv
// Shared types, codes and sizes for the deque with value erase.
package dqve_pkg;

  localparam int DATA_W    = 32;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 16;

  // Request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_ERASE      = 3'd4,
    ACT_PEEK_FRONT = 3'd5
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
  } dqve_res_t;

endpackage

FILE: rtl/core/dqve_req_if.sv
// Request channel: action and value with valid/ready.
interface dqve_req_if;
  import dqve_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

FILE: rtl/core/dqve_rsp_if.sv
// Response channel: data, status, empty flag and occupancy with valid/ready.
interface dqve_rsp_if #(
  parameter int DEPTH = dqve_pkg::DEPTH_DEF
);
  import dqve_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0]      status;
  logic                     is_empty;
  logic [CNT_W-1:0]         occupancy;

  modport source (output valid, data, status, is_empty, occupancy, input ready);
  modport sink   (input valid, data, status, is_empty, occupancy, output ready);
endinterface

FILE: rtl/core/dqve_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dqve_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/dqve_seq.sv
// Sequencer: ring pointers, entry count and the read/modify/write walk over the slot RAM.
module dqve_seq #(
  parameter int DEPTH = dqve_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  dqve_req_if.sink                   req,
  output dqve_pkg::dqve_res_t        res,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import dqve_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam logic [AW1-1:0] DEPTH_W  = AW1'(DEPTH);
  localparam logic [AW-1:0]  LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0]  FULL_CNT = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_ERASE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                   state, state_next;
  logic [AW-1:0]            front, front_next;
  logic [CW-1:0]            count_next;
  logic signed [DATA_W-1:0] val_reg, val_next;
  logic [CW-1:0]            rd_off, rd_off_next;
  logic [CW-1:0]            kept, kept_next;
  logic                     chk, chk_next;
  dqve_res_t                res_next;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata, ram_rdata;

  logic                     full, empty;
  logic [AW-1:0]            front_dec;
  logic [CW-1:0]            cnt_m1;

  // Ring position offset places behind base
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW1-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) sum = sum - DEPTH_W;
    return sum[AW-1:0];
  endfunction

  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? LAST_IDX : front - 1'b1;
  assign cnt_m1    = count - 1'b1;

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // Next-state and RAM access logic
  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = count;
    val_next    = val_reg;
    rd_off_next = rd_off;
    kept_next   = kept;
    chk_next    = 1'b0;
    res_next    = res;
    ram_we      = 1'b0;
    ram_waddr   = front;
    ram_wdata   = req.value;
    ram_re      = 1'b0;
    ram_raddr   = front;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_next.data   = '0;
          res_next.status = ST_OK;
          state_next      = S_DONE;
          unique case (req.action)
            ACT_PUSH_FRONT: begin
              if (full) begin
                res_next.status = ST_FULL;
              end else begin
                front_next = front_dec;
                ram_we     = 1'b1;
                ram_waddr  = front_dec;
                count_next = count + 1'b1;
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                res_next.status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = ring_add(front, count[AW-1:0]);
                count_next = count + 1'b1;
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                res_next.status = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = front;
                front_next = ring_add(front, AW'(1));
                count_next = cnt_m1;
                state_next = S_READ;
              end
            end
            ACT_POP_BACK: begin
              if (empty) begin
                res_next.status = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = ring_add(front, cnt_m1[AW-1:0]);
                count_next = cnt_m1;
                state_next = S_READ;
              end
            end
            ACT_PEEK_FRONT: begin
              if (empty) begin
                res_next.status = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = front;
                state_next = S_READ;
              end
            end
            ACT_ERASE: begin
              val_next    = req.value;
              rd_off_next = '0;
              kept_next   = '0;
              if (!empty) begin
                state_next = S_ERASE;
              end
            end
            default: ;
          endcase
        end
      end

      // Read data from the registered RAM port lands in the cycle after the address
      S_READ: begin
        res_next.data = ram_rdata;
        state_next    = S_DONE;
      end

      // Read entry i while the entry read last cycle is kept or dropped
      S_ERASE: begin
        if (rd_off != count) begin
          ram_re      = 1'b1;
          ram_raddr   = ring_add(front, rd_off[AW-1:0]);
          rd_off_next = rd_off + 1'b1;
          chk_next    = 1'b1;
        end
        if (chk && (ram_rdata != val_reg)) begin
          ram_we    = 1'b1;
          ram_waddr = ring_add(front, kept[AW-1:0]);
          ram_wdata = ram_rdata;
          kept_next = kept + 1'b1;
        end
        if ((rd_off == count) && !chk) begin
          count_next = kept;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      chk   <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      chk   <= chk_next;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    val_reg <= val_next;
    rd_off  <= rd_off_next;
    kept    <= kept_next;
    res     <= res_next;
  end

  dqve_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Occupancy never exceeds the ring size
  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("entry count above depth");

  // An accepted push that is not refused adds exactly one entry
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !full &&
     (req.action == ACT_PUSH_FRONT || req.action == ACT_PUSH_BACK))
    |=> (count == $past(count) + 1'b1))
    else $error("push did not add one entry");

  // Compaction never writes the slot being read in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write collide on one slot");

  // Erase never grows the queue
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ERASE) |=> (count <= $past(count)))
    else $error("erase grew the queue");

endmodule

FILE: rtl/core/deque_with_value_erase_unit.sv
// Top level of the deque with value erase: sequencer, slot RAM and result register.
//
// A bounded double-ended queue of signed 32-bit words, DEPTH entries deep.
// Requests arrive on req (action, value) and each returns exactly one
// response on rsp (data, status, is_empty, occupancy); both channels
// transfer when valid and ready are high at a rising clock edge.
// Each request passes the sequencer states S_IDLE and S_DONE; pops and
// peeks also take one RAM read in S_READ, and an erase of a nonempty queue
// walks S_ERASE as a read-modify-write walk over the slot RAM, as it reads every
// held entry once and writes the survivors back in order behind the read pointer.
// Pushes, refused pushes, empty pops, erase of an empty queue and no-ops go
// straight from S_IDLE to S_DONE. rsp.valid is registered from S_DONE, and a new
// request is taken only once the last result has moved into the output register.
// If the receiver stalls, the held response stays put, one further request
// may be accepted and finished, and then req.ready stays low until rsp drains.
// Synchronous reset empties the queue and drops any pending response;
// slot contents are not cleared and need no clearing pass.
module deque_with_value_erase_unit #(
  parameter int DEPTH = dqve_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dqve_req_if.sink   req,
  dqve_rsp_if.source rsp
);
  import dqve_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  dqve_res_t       res;
  logic            res_valid;
  logic            res_ready;
  logic [CW-1:0]   count;

  dqve_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .count     (count)
  );

  // Output register takes a result whenever it is empty or being drained
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp.data      <= res.data;
      rsp.status    <= res.status;
      rsp.is_empty  <= (count == '0);
      rsp.occupancy <= count;
    end
  end

endmodule

FILE: sim/deque_with_value_erase_unit_test.sv
// Self-checking testbench for the deque with value erase: directed and random requests against a predictor.
module deque_with_value_erase_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dqve_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int PHASE_ITEMS = 300;
  localparam int STALL_LIMIT = 4000;

  // Action codes the block treats as no-ops
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  // Burst flavors for the random part
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] CORNER_WORDS [5] = '{WORD_MIN, WORD_MAX, -32'sd1, 32'sd0,
                                                            32'sd7};

  // Idling per phase: sender idle and receiver stall, percent of cycles
  localparam int SEND_IDLE [4] = '{0, 50, 0, 36};
  localparam int RECV_IDLE [4] = '{0, 0, 50, 36};

  typedef struct {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic                     is_empty;
    logic [CNT_W-1:0]         occupancy;
  } outcome_t;

  // Deque predictor and response checker
  class deque_scoreboard;
    logic signed [DATA_W-1:0] held[$];
    outcome_t                 outstanding[$];
    int                       errors;

    function void note_request(logic [ACTION_W-1:0] action, logic signed [DATA_W-1:0] value);
      outcome_t                 want;
      logic signed [DATA_W-1:0] kept[$];
      want.data   = '0;
      want.status = ST_OK;
      case (action)
        ACT_PUSH_FRONT: begin
          if (held.size() >= DEPTH) want.status = ST_FULL;
          else held.insert(0, value);
        end
        ACT_PUSH_BACK: begin
          if (held.size() >= DEPTH) want.status = ST_FULL;
          else held.push_back(value);
        end
        ACT_POP_FRONT: begin
          if (held.size() == 0) want.status = ST_EMPTY;
          else begin
            want.data = held[0];
            held.delete(0);
          end
        end
        ACT_POP_BACK: begin
          if (held.size() == 0) want.status = ST_EMPTY;
          else want.data = held.pop_back();
        end
        ACT_ERASE: begin
          // survivors keep their order
          foreach (held[i]) if (held[i] != value) kept.push_back(held[i]);
          held = kept;
        end
        ACT_PEEK_FRONT: begin
          if (held.size() == 0) want.status = ST_EMPTY;
          else want.data = held[0];
        end
        default: ;
      endcase
      want.is_empty  = (held.size() == 0);
      want.occupancy = CNT_W'(held.size());
      outstanding.push_back(want);
    endfunction

    function void check_response(logic signed [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                                 logic is_empty, logic [CNT_W-1:0] occupancy);
      outcome_t want;
      if (outstanding.size() == 0) begin
        $error("response transfer with no request outstanding");
        errors++;
        return;
      end
      want = outstanding[0];
      outstanding.delete(0);
      if (data !== want.data) begin
        $error("data: expected %0d, got %0d", want.data, data);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
        errors++;
      end
      if (occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   recv_stall_pct;
  int   send_idle_pct;
  bit   receiver_calm;
  bit   sender_calm;
  int   quiet_cycles;

  deque_scoreboard ledger = new();

  dqve_req_if req_ch ();
  dqve_rsp_if #(.DEPTH(DEPTH)) rsp_ch ();

  deque_with_value_erase_unit #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Response side: random back-pressure
  always @(negedge clk) begin
    rsp_ch.ready <= receiver_calm || ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every response transfer
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      ledger.check_response(rsp_ch.data, rsp_ch.status, rsp_ch.is_empty, rsp_ch.occupancy);
  end

  // Watchdog: give up after a long run of cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** deque_with_value_erase_unit: FAILED **");
      $finish;
    end
  end

  // Present one request from a falling edge, hold it until the transfer, then maybe idle
  task automatic send_request(input logic [ACTION_W-1:0] action,
                              input logic signed [DATA_W-1:0] value);
    req_ch.valid  = 1'b1;
    req_ch.action = action;
    req_ch.value  = value;
    do @(posedge clk); while (!req_ch.ready);
    ledger.note_request(action, value);
    @(negedge clk);
    while (!sender_calm && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid  = 1'b0;
      req_ch.action = ACTION_W'($urandom_range(7));
      req_ch.value  = $urandom;
      @(negedge clk);
    end
  endtask

  // Sender holds off until every outstanding response is back
  task automatic hold_until_drained();
    req_ch.valid = 1'b0;
    while (ledger.outstanding.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] draw_word();
    case ($urandom_range(3))
      0, 1:    return $urandom_range(3);   // small values so erase hits duplicates
      2:       return $urandom;
      default: return CORNER_WORDS[$urandom_range(4)];
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] draw_action(int mode);
    int roll;
    roll = $urandom_range(99);
    if (roll < 2)  return $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
    if (roll < 10) return ACT_ERASE;
    if (roll < 16) return ACT_PEEK_FRONT;
    roll = $urandom_range(99);
    if ((mode == MODE_FILL && roll < 80) || (mode == MODE_DRAIN && roll >= 80) ||
        (mode == MODE_MIXED && roll < 50))
      return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  initial begin
    int                       phase;
    int                       sent;
    int                       mode;
    int                       burst_len;
    logic [ACTION_W-1:0]      act;
    logic signed [DATA_W-1:0] word;

    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_PUSH_FRONT;
    req_ch.value   = '0;
    rsp_ch.ready   = 1'b0;
    recv_stall_pct = 0;
    send_idle_pct  = 0;
    receiver_calm  = 1'b1;
    sender_calm    = 1'b1;
    quiet_cycles   = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty queue corner cases and spare action codes
    send_request(ACT_PEEK_FRONT, 32'sd0);
    send_request(ACT_POP_FRONT, WORD_MAX);
    send_request(ACT_POP_BACK, -32'sd1);
    send_request(ACT_ERASE, 32'sd0);
    send_request(ACT_SPARE_A, WORD_MAX);
    send_request(ACT_SPARE_B, WORD_MIN);
    // pop back of the only entry
    send_request(ACT_PUSH_BACK, WORD_MAX);
    send_request(ACT_POP_BACK, 32'sd0);
    // fill from both ends, then push into a full queue
    for (int i = 0; i < DEPTH; i++)
      send_request(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, CORNER_WORDS[i % 5]);
    send_request(ACT_PUSH_FRONT, 32'sd1);
    send_request(ACT_PUSH_BACK, 32'sd2);
    send_request(ACT_PEEK_FRONT, 32'sd0);
    send_request(ACT_ERASE, 32'sd7);        // several copies spread through the ring
    send_request(ACT_ERASE, 32'sd12345);    // no match
    send_request(ACT_POP_FRONT, 32'sd0);
    send_request(ACT_POP_BACK, 32'sd0);
    hold_until_drained();

    // Random: fill, drain and mixed bursts under each idling pattern
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct <= RECV_IDLE[phase];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        mode          = $urandom_range(MODE_MIXED);
        burst_len     = $urandom_range(40, 8);
        sender_calm   = ($urandom_range(3) == 0);
        receiver_calm <= ($urandom_range(3) == 0);
        repeat (burst_len) begin
          act  = draw_action(mode);
          word = draw_word();
          // aim erase at a held value half the time
          if (act == ACT_ERASE && ledger.held.size() != 0 && $urandom_range(1))
            word = ledger.held[$urandom_range(ledger.held.size() - 1)];
          send_request(act, word);
          if (act != ACT_SPARE_A && act != ACT_SPARE_B) sent++;
        end
      end
      hold_until_drained();
    end

    // Let the tail drain, then a few more cycles for anything unexpected
    req_ch.valid = 1'b0;
    while (ledger.outstanding.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (ledger.errors == 0 && ledger.outstanding.size() == 0)
      $display("** deque_with_value_erase_unit: PASSED **");
    else
      $display("** deque_with_value_erase_unit: FAILED **");
    $finish;
  end

endmodule

FILE: deque_with_value_erase_unit.f
rtl/core/dqve_pkg.sv
rtl/core/dqve_req_if.sv
rtl/core/dqve_rsp_if.sv
rtl/core/dqve_ram.sv
rtl/core/dqve_seq.sv
rtl/core/deque_with_value_erase_unit.sv
sim/deque_with_value_erase_unit_test.sv
